// ===== rtl/core/urrf_pkg.sv =====
package urrf_pkg;

    localparam int BYTE_W        = 8;
    localparam int RELAY_N       = 4;
    localparam int OVERSAMPLE    = 3;
    localparam int FIRST_DELAY   = 4;
    localparam int FRAME_SLOTS   = 9;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_MASK = 3'b010,
        FS_CMD  = 3'b100
    } t_frame_state;

    // sampler -> decoder word
    typedef struct packed {
        logic              got;
        logic [BYTE_W-1:0] value;
    } t_byte_evt;

    typedef struct packed {
        logic [RELAY_N-1:0] relay_levels;
        logic               byte_valid;
        logic [BYTE_W-1:0]  byte_value;
        logic               frame_done;
    } t_result;

endpackage

// ===== rtl/core/urrf_fifo.sv =====
module urrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = urrf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/urrf_front.sv =====
module urrf_front #(
    parameter int OVERSAMPLE  = urrf_pkg::OVERSAMPLE,
    parameter int FIRST_DELAY = urrf_pkg::FIRST_DELAY,
    parameter int FRAME_SLOTS = urrf_pkg::FRAME_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_rx_level,
    output urrf_pkg::t_byte_evt o_evt
);

    localparam int TMAX = (OVERSAMPLE > FIRST_DELAY) ? OVERSAMPLE : FIRST_DELAY;
    localparam int TW   = $clog2(TMAX + 1);
    localparam int BW   = $clog2(FRAME_SLOTS + 1);
    localparam int DW   = urrf_pkg::BYTE_W;

    logic          r_receiving, n_receiving;
    logic [TW-1:0] r_tick, n_tick;
    logic [BW-1:0] r_bits, n_bits;
    logic [DW-1:0] r_shift, n_shift;
    logic [TW-1:0] tick_dec;
    logic [BW-1:0] bits_dec;

    assign tick_dec = r_tick - 1'b1;
    assign bits_dec = r_bits - 1'b1;

    always_comb begin
        n_receiving = r_receiving;
        n_tick      = r_tick;
        n_bits      = r_bits;
        n_shift     = r_shift;
        o_evt.got   = 1'b0;
        o_evt.value = '0;
        if (i_valid) begin
            if (r_receiving) begin
                if (tick_dec == '0) begin
                    n_tick = TW'(OVERSAMPLE);
                    n_bits = bits_dec;
                    if (bits_dec == '0) begin
                        // stop slot: deliver, line level ignored
                        n_receiving = 1'b0;
                        o_evt.got   = 1'b1;
                        o_evt.value = r_shift;
                    end else begin
                        n_shift = {i_rx_level, r_shift[DW-1:1]};
                    end
                end else begin
                    n_tick = tick_dec;
                end
            end else if (!i_rx_level) begin
                n_receiving = 1'b1;
                n_tick      = TW'(FIRST_DELAY);
                n_bits      = BW'(FRAME_SLOTS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_tick      <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_tick      <= n_tick;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
        end
    end

endmodule

// ===== rtl/core/urrf_back.sv =====
module urrf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [urrf_pkg::BYTE_W-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    input  urrf_pkg::t_byte_evt           i_evt,
    output urrf_pkg::t_result             o_res
);

    localparam int RN = urrf_pkg::RELAY_N;

    logic [urrf_pkg::BYTE_W-1:0] r_header;
    urrf_pkg::t_frame_state      r_state, n_state;
    logic [RN-1:0]               r_mask, n_mask;
    logic [RN-1:0]               r_relay, n_relay;
    logic                        done;

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_relay = r_relay;
        done    = 1'b0;
        if (i_valid && i_evt.got) begin
            if (i_evt.value == r_header) begin
                // header always restarts the frame
                n_state = urrf_pkg::FS_MASK;
            end else begin
                unique case (r_state)
                    urrf_pkg::FS_IDLE: n_state = urrf_pkg::FS_IDLE;
                    urrf_pkg::FS_MASK: begin
                        n_mask  = i_evt.value[RN-1:0];
                        n_state = urrf_pkg::FS_CMD;
                    end
                    urrf_pkg::FS_CMD: begin
                        n_relay = (r_relay & ~r_mask)
                                | ((i_evt.value != '0) ? r_mask : '0);
                        n_state = urrf_pkg::FS_IDLE;
                        done    = 1'b1;
                    end
                    default: n_state = urrf_pkg::FS_IDLE;
                endcase
            end
        end
        o_res.relay_levels = n_relay;
        o_res.byte_valid   = i_evt.got;
        o_res.byte_value   = i_evt.value;
        o_res.frame_done   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= urrf_pkg::HEADER_RESET;
            r_state  <= urrf_pkg::FS_IDLE;
            r_relay  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_relay <= n_relay;
        end
    end

    // written by the mask slot before any read
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
    end

endmodule

// ===== rtl/core/uart_rx_relay_frame_controller_core.sv =====
// channel   direction  handshake            word
// sample    in         push / full          i_rx_level
// result    out        pop / empty          o_relay_levels, o_byte_valid,
//                                           o_byte_value, o_frame_done
// config    in         i_cfg_we (no wait)   i_cfg_wdata = header byte
//
// One sample in and one result out per cycle, sustained while the result side
// pops every word; a sample's result is registered in the middle queue and then
// in the output queue (sampler -> 2-word queue -> frame decoder -> 2-word output queue).
// Reset is synchronous, active low; both queues come up empty.
// A stalled output fills the output queue, then the middle queue, then full
// rises; the sampler and decoder each hold while their downstream is full.
module uart_rx_relay_frame_controller_core #(
    parameter int OVERSAMPLE  = urrf_pkg::OVERSAMPLE,
    parameter int FIRST_DELAY = urrf_pkg::FIRST_DELAY,
    parameter int FRAME_SLOTS = urrf_pkg::FRAME_SLOTS,
    parameter int QUEUE_DEPTH = urrf_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_rx_level,
    output logic                                empty,
    input  logic                                pop,
    output logic [urrf_pkg::RELAY_N-1:0]        o_relay_levels,
    output logic                                o_byte_valid,
    output logic [urrf_pkg::BYTE_W-1:0]         o_byte_value,
    output logic                                o_frame_done,
    input  logic                                i_cfg_we,
    input  logic [urrf_pkg::BYTE_W-1:0]         i_cfg_wdata
);

    urrf_pkg::t_byte_evt front_evt, mid_evt;
    urrf_pkg::t_result   back_res, out_res;
    logic                accept, mid_empty, out_full, back_go;

    assign accept  = push && !full;
    assign back_go = !mid_empty && !out_full;

    urrf_front #(
        .OVERSAMPLE (OVERSAMPLE),
        .FIRST_DELAY(FIRST_DELAY),
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_rx_level(i_rx_level),
        .o_evt     (front_evt)
    );

    urrf_fifo #(
        .WIDTH($bits(urrf_pkg::t_byte_evt)),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (accept),
        .i_wdata(front_evt),
        .o_full (full),
        .i_rd   (back_go),
        .o_rdata(mid_evt),
        .o_empty(mid_empty)
    );

    urrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (back_go),
        .i_evt      (mid_evt),
        .o_res      (back_res)
    );

    urrf_fifo #(
        .WIDTH($bits(urrf_pkg::t_result)),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (back_go),
        .i_wdata(back_res),
        .o_full (out_full),
        .i_rd   (pop),
        .o_rdata(out_res),
        .o_empty(empty)
    );

    assign o_relay_levels = out_res.relay_levels;
    assign o_byte_valid   = out_res.byte_valid;
    assign o_byte_value   = out_res.byte_value;
    assign o_frame_done   = out_res.frame_done;

endmodule

// ===== rtl/core/urrf_checker.sv =====
module urrf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [urrf_pkg::RELAY_N-1:0] o_relay_levels,
    input  logic                         o_byte_valid,
    input  logic [urrf_pkg::BYTE_W-1:0]  o_byte_value,
    input  logic                         o_frame_done
);

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a frame only completes on a delivered word
    a_done_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_done |-> o_byte_valid)
        else $error("frame_done without byte_valid");

    // no byte, no byte value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_byte_value == '0)
        else $error("byte_value nonzero without byte_valid");

    // relays move only on a completed frame
    a_relay_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) ##1 (!empty && !o_frame_done)
        |-> o_relay_levels == $past(o_relay_levels))
        else $error("relay levels changed outside a frame");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_relay_levels)
                           && $stable(o_byte_value))
        else $error("stalled word changed");

endmodule

bind uart_rx_relay_frame_controller_core urrf_checker u_urrf_checker (.*);
